/* rtl/ahfr_pkg.sv */
// Package for the ASCII hex frame receiver with LRC check.
// Character classes, queue entry and result item types, status codes.
// No dependencies.
package ahfr_pkg;

  // Received character width and result field widths
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;
  localparam int NIBBLE_W = 4;

  // Default frame length limit, ':' and CR included
  localparam int MAX_FRAME_CHARS_DEF = 128;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Character classes decided by the front
  typedef logic [2:0] ahfr_class_t;
  localparam ahfr_class_t CLS_COLON = 3'd0;
  localparam ahfr_class_t CLS_CR    = 3'd1;
  localparam ahfr_class_t CLS_LF    = 3'd2;
  localparam ahfr_class_t CLS_HEX   = 3'd3;
  localparam ahfr_class_t CLS_OTHER = 3'd4;

  // ASCII codes
  localparam logic [CHAR_W-1:0] ASC_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] ASC_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] ASC_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] ASC_0     = 8'h30;
  localparam logic [CHAR_W-1:0] ASC_9     = 8'h39;
  localparam logic [CHAR_W-1:0] ASC_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] ASC_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] ASC_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] ASC_LF_HEX = 8'h66;
  localparam logic [CHAR_W-1:0] HEX_TEN   = 8'd10;

  // Result item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Frame end status codes
  typedef logic [STATUS_W-1:0] ahfr_status_t;
  localparam ahfr_status_t ST_OK     = 3'd0;
  localparam ahfr_status_t ST_NONHEX = 3'd1;
  localparam ahfr_status_t ST_LRC    = 3'd2;
  localparam ahfr_status_t ST_ABORT  = 3'd3;
  localparam ahfr_status_t ST_FORMAT = 3'd4;

  // One classified character as queued
  typedef struct packed {
    ahfr_class_t         cls;
    logic [NIBBLE_W-1:0] nibble;
  } ahfr_entry_t;

  // One result item
  typedef struct packed {
    logic                kind;
    logic [CHAR_W-1:0]   data;
    ahfr_status_t        status;
    logic [COUNT_W-1:0]  count;
  } ahfr_item_t;

  // Queue handshake toward the back
  typedef struct packed {
    logic        valid;
    ahfr_entry_t entry;
  } ahfr_q_out_t;

endpackage

/* rtl/ahfr_if.sv */
// Channel interfaces for the ASCII hex frame receiver.
// Character input channel and result item channel. Depends on ahfr_pkg.
interface ahfr_char_if
  import ahfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface ahfr_item_if
  import ahfr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                item_kind;
  logic [CHAR_W-1:0]   data_byte;
  logic [STATUS_W-1:0] frame_status;
  logic [COUNT_W-1:0]  byte_count;

  modport source (output valid, output item_kind, output data_byte,
                  output frame_status, output byte_count, input ready);
  modport sink (input valid, input item_kind, input data_byte,
                input frame_status, input byte_count, output ready);
endinterface

/* rtl/ahfr_front.sv */
// Front end: accepts characters and classifies them (framing code, hex digit or other).
// Depends on ahfr_pkg and ahfr_if; feeds ahfr_queue.
module ahfr_front
  import ahfr_pkg::*;
(
  ahfr_char_if.sink    char_in,
  input  logic         q_full,
  output logic         q_push,
  output ahfr_entry_t  q_entry
);

  logic [CHAR_W-1:0]   c;
  logic                is_dig;
  logic                is_upper;
  logic                is_lower;
  logic [NIBBLE_W-1:0] val;

  assign c = char_in.rx_char;

  // Accept whenever the queue has room
  assign char_in.ready = !q_full;
  assign q_push        = char_in.valid && !q_full;

  // Hex digit decode
  assign is_dig   = (c >= ASC_0) && (c <= ASC_9);
  assign is_upper = (c >= ASC_UA) && (c <= ASC_UF);
  assign is_lower = (c >= ASC_LA) && (c <= ASC_LF_HEX);

  always_comb begin
    priority if (is_dig) begin
      val = NIBBLE_W'(c - ASC_0);
    end else if (is_upper) begin
      val = NIBBLE_W'(c - ASC_UA + HEX_TEN);
    end else if (is_lower) begin
      val = NIBBLE_W'(c - ASC_LA + HEX_TEN);
    end else begin
      val = '0;
    end
  end

  // Character class
  always_comb begin
    q_entry.nibble = val;
    priority if (c == ASC_COLON) begin
      q_entry.cls = CLS_COLON;
    end else if (c == ASC_CR) begin
      q_entry.cls = CLS_CR;
    end else if (c == ASC_LF) begin
      q_entry.cls = CLS_LF;
    end else if (is_dig || is_upper || is_lower) begin
      q_entry.cls = CLS_HEX;
    end else begin
      q_entry.cls = CLS_OTHER;
    end
  end

endmodule

/* rtl/ahfr_queue.sv */
// Short FIFO of classified characters between front and back.
// Depends on ahfr_pkg.
module ahfr_queue
  import ahfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ahfr_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output ahfr_q_out_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ahfr_entry_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full        = (count == CNT_W'(QUEUE_DEPTH));
  assign head.valid  = (count != '0);
  assign head.entry  = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

/* rtl/ahfr_back.sv */
// Back end: framing state machine, byte pairing, LRC sum and result register.
// Depends on ahfr_pkg and ahfr_if; reads ahfr_queue.
module ahfr_back
  import ahfr_pkg::*;
#(
  parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ahfr_q_out_t    head,
  output logic           pop,
  ahfr_item_if.source    item_out
);

  localparam int CC_W = $clog2(MAX_FRAME_CHARS + 1);
  localparam logic [CC_W-1:0] CC_MAX = CC_W'(MAX_FRAME_CHARS);
  localparam logic [COUNT_W-1:0] BE_MAX = '1;

  // Framing states
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_BODY     = 2'd1;
  localparam logic [1:0] MODE_AFTER_CR = 2'd2;

  logic [1:0]          mode, mode_next;
  logic [CC_W-1:0]     char_count, char_count_next;
  logic [NIBBLE_W-1:0] high_nibble, high_nibble_next;
  logic                half_pair, half_pair_next;
  logic [CHAR_W-1:0]   held_byte, held_byte_next;
  logic                held_valid, held_valid_next;
  logic [CHAR_W-1:0]   lrc_sum, lrc_sum_next;
  logic                bad_hex_seen, bad_hex_seen_next;
  logic [COUNT_W-1:0]  bytes_emitted, bytes_emitted_next;

  logic                out_valid;
  ahfr_item_t          out_item;

  logic                take;
  logic                open_req;
  logic                res_valid;
  ahfr_item_t          res;
  logic [NIBBLE_W-1:0] nib;
  logic [CHAR_W-1:0]   pair_byte;
  logic [CC_W-1:0]     cc_inc;

  // Pop when the result register is free or is being emptied
  assign take = head.valid && (!out_valid || item_out.ready);
  assign pop  = take;

  assign nib       = (head.entry.cls == CLS_HEX) ? head.entry.nibble : '0;
  assign pair_byte = {high_nibble, nib};
  assign cc_inc    = (char_count < CC_MAX) ? char_count + 1'b1 : char_count;

  // Framing step for the character at the queue head
  always_comb begin
    mode_next          = mode;
    char_count_next    = char_count;
    high_nibble_next   = high_nibble;
    half_pair_next     = half_pair;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    lrc_sum_next       = lrc_sum;
    bad_hex_seen_next  = bad_hex_seen;
    bytes_emitted_next = bytes_emitted;
    open_req           = 1'b0;
    res_valid          = 1'b0;
    res                = '0;

    unique case (mode)
      MODE_BODY: begin
        if (head.entry.cls == CLS_COLON) begin
          res_valid = 1'b1;
          res       = '{KIND_END, '0, ST_ABORT, bytes_emitted};
          open_req  = 1'b1;
        end else begin
          char_count_next = cc_inc;
          if (head.entry.cls == CLS_CR) begin
            mode_next = MODE_AFTER_CR;
          end else begin
            if (head.entry.cls != CLS_HEX) begin
              bad_hex_seen_next = 1'b1;
            end
            if (!half_pair) begin
              high_nibble_next = nib;
              half_pair_next   = 1'b1;
            end else begin
              half_pair_next = 1'b0;
              if (held_valid) begin
                res_valid = 1'b1;
                res       = '{KIND_DATA, held_byte, ST_OK, '0};
                if (bytes_emitted != BE_MAX) begin
                  bytes_emitted_next = bytes_emitted + 1'b1;
                end
              end
              held_byte_next  = pair_byte;
              held_valid_next = 1'b1;
              lrc_sum_next    = lrc_sum + pair_byte;
            end
          end
          // Overflow abort replaces any data result
          if (cc_inc >= CC_MAX) begin
            mode_next = MODE_IDLE;
            res_valid = 1'b1;
            res       = '{KIND_END, '0, ST_ABORT, bytes_emitted_next};
          end
        end
      end
      MODE_AFTER_CR: begin
        res_valid = 1'b1;
        mode_next = MODE_IDLE;
        priority if (head.entry.cls == CLS_COLON) begin
          res      = '{KIND_END, '0, ST_ABORT, bytes_emitted};
          open_req = 1'b1;
        end else if (head.entry.cls != CLS_LF) begin
          res = '{KIND_END, '0, ST_ABORT, bytes_emitted};
        end else if (bad_hex_seen) begin
          res = '{KIND_END, '0, ST_NONHEX, bytes_emitted};
        end else if (half_pair || !held_valid) begin
          res = '{KIND_END, '0, ST_FORMAT, bytes_emitted};
        end else if (lrc_sum != '0) begin
          res = '{KIND_END, '0, ST_LRC, bytes_emitted};
        end else begin
          res = '{KIND_END, '0, ST_OK, bytes_emitted};
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        if (head.entry.cls == CLS_COLON) begin
          open_req = 1'b1;
        end
      end
    endcase

    // New frame after ':'
    if (open_req) begin
      mode_next          = MODE_BODY;
      char_count_next    = CC_W'(1);
      high_nibble_next   = '0;
      half_pair_next     = 1'b0;
      held_byte_next     = '0;
      held_valid_next    = 1'b0;
      lrc_sum_next       = '0;
      bad_hex_seen_next  = 1'b0;
      bytes_emitted_next = '0;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      char_count    <= '0;
      high_nibble   <= '0;
      half_pair     <= 1'b0;
      held_byte     <= '0;
      held_valid    <= 1'b0;
      lrc_sum       <= '0;
      bad_hex_seen  <= 1'b0;
      bytes_emitted <= '0;
    end else if (take) begin
      mode          <= mode_next;
      char_count    <= char_count_next;
      high_nibble   <= high_nibble_next;
      half_pair     <= half_pair_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      lrc_sum       <= lrc_sum_next;
      bad_hex_seen  <= bad_hex_seen_next;
      bytes_emitted <= bytes_emitted_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res_valid;
    end else if (item_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_item <= res;
    end
  end

  assign item_out.valid        = out_valid;
  assign item_out.item_kind    = out_item.kind;
  assign item_out.data_byte    = out_item.data;
  assign item_out.frame_status = out_item.status;
  assign item_out.byte_count   = out_item.count;

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind == KIND_DATA) |->
      (out_item.status == ST_OK && out_item.count == '0))
    else $error("data item carries frame end fields");
  a_data_needs_held: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && res.kind == KIND_DATA) |-> (held_valid && mode == MODE_BODY))
    else $error("data byte without a held byte");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (take && mode == MODE_IDLE) |=> !out_valid)
    else $error("result from idle character");
  a_cc_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= CC_MAX) else $error("character count past limit");

endmodule

/* rtl/ascii_hex_frame_receiver_lrc_top.sv */
// Throughput: one character per cycle; the front, a two-entry queue and the back each stall alone.
// An accepted character's result passes through the queue and then the result register.
// A data byte appears when the following hex pair completes; the frame end item at the character after CR,
// at a ':' inside a frame, or at the frame length limit. Reset (rst, synchronous): framing goes idle,
// queue empties, result register clears. Top level of the ASCII hex frame receiver; depends on ahfr_pkg,
// ahfr_if, ahfr_front, ahfr_queue and ahfr_back.
module ascii_hex_frame_receiver_lrc_top
  import ahfr_pkg::*;
#(
  parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ahfr_char_if.sink   char_in,
  ahfr_item_if.source item_out
);

  logic        q_full;
  logic        q_push;
  ahfr_entry_t q_entry;
  logic        q_pop;
  ahfr_q_out_t q_head;

  // Classify incoming characters
  ahfr_front u_front (
    .char_in (char_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Decoupling queue
  ahfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head       (q_head)
  );

  // Framing and results
  ahfr_back #(
    .MAX_FRAME_CHARS (MAX_FRAME_CHARS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .pop      (q_pop),
    .item_out (item_out)
  );

endmodule

/* sim/ascii_hex_frame_receiver_lrc_top_tb.sv */
// Testbench for ascii_hex_frame_receiver_lrc_top: character frames in, decoded bytes and
// frame end status out, checked against a cycle-free model of the framing rules.
// Depends on ahfr_pkg, ahfr_if and the RTL of the receiver.
module ascii_hex_frame_receiver_lrc_top_tb
  import ahfr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHARS   = MAX_FRAME_CHARS_DEF;
  localparam int RAND_CHARS  = 1600;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_GAP     = 18;

  typedef logic [CHAR_W-1:0] byte_q_t[$];

  // Ways a generated frame can be damaged
  typedef enum int {
    FLAW_NONE, FLAW_LRC, FLAW_NONHEX, FLAW_ODD, FLAW_AFTER_CR, FLAW_RESTART, FLAW_CR_RESTART
  } flaw_t;

  // Framing model plus the store of expected result items
  class frame_checker;
    typedef enum logic [1:0] {MODE_IDLE, MODE_BODY, MODE_AFTER_CR} mode_t;

    mode_t               mode;
    int                  frame_chars;
    logic [NIBBLE_W-1:0] hi_nib;
    bit                  half_pair;
    logic [CHAR_W-1:0]   held_byte;
    bit                  held_valid;
    logic [CHAR_W-1:0]   byte_sum;
    bit                  bad_hex;
    logic [COUNT_W-1:0]  emitted;

    ahfr_item_t expected_items[$];
    int         faults;
    int         data_seen;
    int         ends_seen[8];

    function new();
      mode        = MODE_IDLE;
      frame_chars = 0;
      clear_frame();
      faults      = 0;
      data_seen   = 0;
      foreach (ends_seen[i]) ends_seen[i] = 0;
    endfunction

    function void clear_frame();
      hi_nib     = '0;
      half_pair  = 0;
      held_byte  = '0;
      held_valid = 0;
      byte_sum   = '0;
      bad_hex    = 0;
      emitted    = '0;
    endfunction

    function void open_frame();
      clear_frame();
      mode        = MODE_BODY;
      frame_chars = 1;
    endfunction

    static function logic [NIBBLE_W-1:0] hex_nibble(logic [CHAR_W-1:0] c, output bit ok);
      ok = 1;
      if (c >= ASC_0 && c <= ASC_9) return NIBBLE_W'(c - ASC_0);
      if (c >= ASC_UA && c <= ASC_UF) return NIBBLE_W'(c - ASC_UA + HEX_TEN);
      if (c >= ASC_LA && c <= ASC_LF_HEX) return NIBBLE_W'(c - ASC_LA + HEX_TEN);
      ok = 0;
      return '0;
    endfunction

    function void push_end(ahfr_status_t st);
      ahfr_item_t it;
      it.kind   = KIND_END;
      it.data   = '0;
      it.status = st;
      it.count  = emitted;
      expected_items.push_back(it);
    endfunction

    // One accepted character; returns 0 when the block just ignores it
    function bit predict_char(logic [CHAR_W-1:0] c);
      logic [NIBBLE_W-1:0] nib;
      logic [CHAR_W-1:0]   b;
      bit                  ok;
      bit                  emit;
      logic [CHAR_W-1:0]   emit_byte;
      ahfr_item_t          it;
      emit      = 0;
      emit_byte = '0;
      case (mode)
        MODE_BODY: begin
          if (c == ASC_COLON) begin
            push_end(ST_ABORT);
            open_frame();
            return 1;
          end
          if (frame_chars < MAX_CHARS) frame_chars++;
          if (c == ASC_CR) begin
            mode = MODE_AFTER_CR;
          end else begin
            nib = hex_nibble(c, ok);
            if (!ok) bad_hex = 1;
            if (!half_pair) begin
              hi_nib    = nib;
              half_pair = 1;
            end else begin
              b         = {hi_nib, nib};
              half_pair = 0;
              if (held_valid) begin
                emit      = 1;
                emit_byte = held_byte;
                if (emitted < 6'd63) emitted++;
              end
              held_byte  = b;
              held_valid = 1;
              byte_sum   = byte_sum + b;
            end
          end
          // overflow abort takes the place of a data byte
          if (frame_chars >= MAX_CHARS) begin
            mode = MODE_IDLE;
            push_end(ST_ABORT);
          end else if (emit) begin
            it.kind   = KIND_DATA;
            it.data   = emit_byte;
            it.status = ST_OK;
            it.count  = '0;
            expected_items.push_back(it);
          end
          return 1;
        end
        MODE_AFTER_CR: begin
          if (c == ASC_COLON) begin
            push_end(ST_ABORT);
            open_frame();
            return 1;
          end
          mode = MODE_IDLE;
          if (c != ASC_LF) push_end(ST_ABORT);
          else if (bad_hex) push_end(ST_NONHEX);
          else if (half_pair || !held_valid) push_end(ST_FORMAT);
          else if (byte_sum != '0) push_end(ST_LRC);
          else push_end(ST_OK);
          return 1;
        end
        default: begin
          mode = MODE_IDLE;
          if (c == ASC_COLON) begin
            open_frame();
            return 1;
          end
          return 0;
        end
      endcase
    endfunction

    function int pending();
      return expected_items.size();
    endfunction

    function void check_item(ahfr_item_t got);
      ahfr_item_t exp;
      if (expected_items.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected item kind=%0d data=%02h status=%0d count=%0d",
                   $realtime, got.kind, got.data, got.status, got.count);
        return;
      end
      exp = expected_items.pop_front();
      if (got.kind !== exp.kind || got.data !== exp.data ||
          got.status !== exp.status || got.count !== exp.count) begin
        faults++;
        if (faults <= 10)
          $display({"%0t: mismatch exp kind=%0d data=%02h status=%0d count=%0d,",
                    " got kind=%0d data=%02h status=%0d count=%0d"},
                   $realtime, exp.kind, exp.data, exp.status, exp.count,
                   got.kind, got.data, got.status, got.count);
      end
      if (exp.kind == KIND_END) ends_seen[exp.status]++;
      else data_seen++;
    endfunction
  endclass

  logic clk;
  logic rst;

  ahfr_char_if char_ch ();
  ahfr_item_if item_ch ();

  ascii_hex_frame_receiver_lrc_top #(
    .MAX_FRAME_CHARS(MAX_CHARS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_ch),
    .item_out (item_ch)
  );

  frame_checker chk;
  int  chars_accepted = 0;
  int  chars_counted  = 0;
  bit  tx_burst       = 0;
  bit  rx_burst       = 0;
  bit  hold_pending   = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Send one character; returns after its transaction, with valid left high
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = (tx_burst || hold_pending) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_ch.valid   <= 1'b1;
    char_ch.rx_char <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    chars_accepted++;
    if (chk.predict_char(c)) chars_counted++;
    if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic close_frame();
    send_char(ASC_CR);
    send_char(ASC_LF);
  endtask

  // Stop offering characters until every expected item has come out
  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] hex_char(logic [NIBBLE_W-1:0] n, bit lower);
    if (n < 4'd10) return ASC_0 + CHAR_W'(n);
    return (lower ? ASC_LA : ASC_UA) + CHAR_W'(n) - HEX_TEN;
  endfunction

  function automatic byte_q_t random_body(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(CHAR_W'($urandom_range(0, 255)));
    return q;
  endfunction

  // Any character that is neither a hex digit, ':' nor CR
  function automatic logic [CHAR_W-1:0] pick_nonhex();
    logic [CHAR_W-1:0] c;
    bit ok;
    do begin
      c = CHAR_W'($urandom_range(0, 255));
      void'(frame_checker::hex_nibble(c, ok));
    end while (ok || c == ASC_COLON || c == ASC_CR);
    return c;
  endfunction

  // Full frame with a correct LRC, then the requested damage
  task automatic send_frame(input byte_q_t body, input flaw_t flaw);
    byte_q_t           digits;
    logic [CHAR_W-1:0] sum;
    logic [CHAR_W-1:0] lrc;
    logic [CHAR_W-1:0] junk;
    int                pos;
    sum = '0;
    foreach (body[i]) sum += body[i];
    lrc = -sum;
    if (flaw == FLAW_LRC) lrc = lrc + CHAR_W'($urandom_range(1, 255));
    body.push_back(lrc);
    foreach (body[i]) begin
      digits.push_back(hex_char(body[i][7:4], 1'($urandom_range(0, 1))));
      digits.push_back(hex_char(body[i][3:0], 1'($urandom_range(0, 1))));
    end
    pos = $urandom_range(0, digits.size() - 1);
    case (flaw)
      FLAW_NONHEX:  digits[pos] = pick_nonhex();
      FLAW_ODD:     digits.delete(pos);
      FLAW_RESTART: digits.insert(pos, ASC_COLON);
      default: ;
    endcase
    send_char(ASC_COLON);
    foreach (digits[i]) send_char(digits[i]);
    send_char(ASC_CR);
    case (flaw)
      FLAW_AFTER_CR: begin
        do junk = CHAR_W'($urandom_range(0, 255));
        while (junk == ASC_LF || junk == ASC_COLON);
        send_char(junk);
      end
      FLAW_CR_RESTART: send_char(ASC_COLON);
      default:         send_char(ASC_LF);
    endcase
  endtask

  // Result side: random stalls, one long hold on request, checks every transaction
  task automatic drain_items();
    int         gap;
    ahfr_item_t got;
    forever begin
      if (hold_pending) begin
        item_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 0;
      end
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        item_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      item_ch.ready <= 1'b1;
      @(posedge clk);
      while (!item_ch.valid) @(posedge clk);
      got.kind   = item_ch.item_kind;
      got.data   = item_ch.data_byte;
      got.status = item_ch.frame_status;
      got.count  = item_ch.byte_count;
      chk.check_item(got);
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
    end
  endtask

  // Hand-picked frames for every status and each corner of the framing
  task automatic run_directed();
    send_text("q?");
    send_char(8'hFF);
    send_char(8'h00);
    close_frame();
    send_text(":");
    close_frame();
    send_text(":0");
    close_frame();
    send_text(":00");
    close_frame();
    send_text(":01");
    close_frame();
    send_text(":aBcD88");
    close_frame();
    send_text(":09FfF8");
    close_frame();
    send_text(":/@G`g");
    close_frame();
    send_text(":12:00");
    close_frame();
    send_text(":12");
    send_char(ASC_CR);
    send_text(":00");
    close_frame();
    send_text(":00");
    send_char(ASC_CR);
    send_text("x");
    // longest frame that fits, then CR overflow, then digit overflow
    send_frame(random_body(61), FLAW_NONE);
    send_frame(random_body(62), FLAW_NONE);
    send_frame(random_body(63), FLAW_NONE);
  endtask

  // Mostly good frames with random content, some damaged ones and line noise
  task automatic run_random();
    bit    hold_asked = 0;
    bit    paused     = 0;
    int    len;
    flaw_t flaw;
    int    start;
    start = chars_counted;
    while (chars_counted - start < RAND_CHARS) begin
      if (!hold_asked && chars_counted - start >= 600) begin
        hold_asked   = 1;
        hold_pending = 1;
      end
      if (!paused && chars_counted - start >= 1200) begin
        paused = 1;
        wait_drained();
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) send_char(CHAR_W'($urandom_range(0, 255)));
      len = ($urandom_range(0, 31) == 0) ? $urandom_range(30, 64) : $urandom_range(0, 8);
      if ($urandom_range(0, 9) < 6) flaw = FLAW_NONE;
      else flaw = flaw_t'($urandom_range(FLAW_LRC, FLAW_CR_RESTART));
      send_frame(random_body(len), flaw);
    end
  endtask

  initial begin
    chk = new();
    rst             <= 1'b1;
    char_ch.valid   <= 1'b0;
    char_ch.rx_char <= '0;
    item_ch.ready   <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      drain_items();
    join_none
    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d characters (%0d not ignored); checked %0d data bytes and frame ends:",
             chars_accepted, chars_counted, chk.data_seen);
    $display("  ok %0d, non-hex %0d, lrc %0d, aborted %0d, format %0d",
             chk.ends_seen[ST_OK], chk.ends_seen[ST_NONHEX], chk.ends_seen[ST_LRC],
             chk.ends_seen[ST_ABORT], chk.ends_seen[ST_FORMAT]);
    if (chk.faults == 0 && chk.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d items still expected", chk.faults, chk.pending());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("timeout, %0d items still expected", chk.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
